[hdl/pmps_pkg.sv]
// Shared types and constants for the priority motor position stepper.
// No dependencies; used by every module of the block by scoped names.
package pmps_pkg;

	// Word kind carried in s_axis_tuser
	typedef enum logic [1:0] {
		FUNC_CMD   = 2'd0,
		FUNC_ACCEL = 2'd1,
		FUNC_JOY   = 2'd2,
		FUNC_TICK  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_REMOTE = 2'd1,
		MODE_JOY    = 2'd2,
		MODE_ACCEL  = 2'd3
	} mode_t;

	localparam int FULL_SCALE_STEPS_DEF = 2048;
	localparam int SERVO_EVERY_DEF      = 16;

	localparam int ANGLE_FULL   = 46080;  // 180 deg in 1/256 units
	localparam int UNIT_FULL    = 32768;
	localparam int ACCEL_OFFSET = 16384;

	// x / 45 == (x * RECIP_45) >> RECIP_SH, exact for x below 2**18
	localparam int RECIP_SH = 24;
	localparam int RECIP_45 = ((1 << RECIP_SH) + 44) / 45;
	localparam int RECIP_W  = 19;

	// Step targets are at most FULL_SCALE_STEPS, carried at full width between parts
	localparam int TGT_W = 13;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		func_t              func;
		mode_t              mode;
		logic [7:0]         prio;
		logic               jvalid;
		logic [TGT_W-1:0]   tgt;
	} q_item_t;

endpackage

[hdl/priority_motor_position_stepper.sv]
// Priority motor position stepper, top level: front pipeline, queue, back part.
// Throughput: one word per clock; the front three-stage scaler and the back's
// step update both take a word every cycle, unless the queue is full or a
// tick word waits for m_axis_tready while the last result is still held.
// Reset: arst_n clears all control state, mode, targets, position and queue.
// Uses pmps_pkg, pmps_front, pmps_queue, pmps_back.
module priority_motor_position_stepper #(
	parameter int FULL_SCALE_STEPS = pmps_pkg::FULL_SCALE_STEPS_DEF,
	parameter int SERVO_EVERY      = pmps_pkg::SERVO_EVERY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cmd_mode, cmd_angle, cmd_priority, accel_sample, joystick_x, joystick_valid
	input  logic [63:0] s_axis_tdata,
	// func
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// step_pulse, clockwise, servo_update, servo_angle, position
	output logic [31:0] m_axis_tdata
);

	logic                 push, pop, q_full, q_empty;
	pmps_pkg::q_item_t    push_item, head;

	pmps_front #(
		.FULL_SCALE_STEPS(FULL_SCALE_STEPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.s_data    (s_axis_tdata),
		.s_user    (s_axis_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	pmps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	pmps_back #(
		.FULL_SCALE_STEPS(FULL_SCALE_STEPS),
		.SERVO_EVERY     (SERVO_EVERY)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.head    (head),
		.pop     (pop),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_data  (m_axis_tdata)
	);

endmodule

[hdl/pmps_front.sv]
// Front part: accepts input words, clamps the sample of each word and scales it
// to a step target in a three stage pipeline. Uses pmps_pkg.
module pmps_front #(
	parameter int FULL_SCALE_STEPS = pmps_pkg::FULL_SCALE_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_valid,
	output logic                 s_ready,
	input  logic [63:0]          s_data,
	input  logic [1:0]           s_user,
	input  logic                 q_full,
	output logic                 push,
	output pmps_pkg::q_item_t    push_item
);

	localparam int TW = $clog2(FULL_SCALE_STEPS + 1);
	localparam int YW = 16 + TW;
	localparam int XW = YW - 10;
	localparam int PW = YW + 9;

	logic en;

	logic [1:0]  in_mode;
	logic [17:0] in_angle;
	logic [15:0] in_accel;
	logic [16:0] in_joy;
	logic [16:0] acc_sum;
	logic [15:0] v_d;

	logic                 valid_s1, valid_s2, valid_s3;
	pmps_pkg::func_t      func_s1, func_s2, func_s3;
	pmps_pkg::mode_t      mode_s1, mode_s2, mode_s3;
	logic [7:0]           prio_s1, prio_s2, prio_s3;
	logic                 jv_s1, jv_s2, jv_s3;
	logic [15:0]          v_s1;
	logic [YW-1:0]        y_s2;
	logic [PW-1:0]        p_s3;
	logic [PW-1:0]        p_d;

	assign en      = !valid_s3 || !q_full;
	assign s_ready = en;

	assign in_mode  = s_data[1:0];
	assign in_angle = s_data[19:2];
	assign in_accel = s_data[43:28];
	assign in_joy   = s_data[60:44];
	assign acc_sum  = {in_accel[15], in_accel} + 17'(pmps_pkg::ACCEL_OFFSET);

	// clamp the sample this word carries
	always_comb begin
		case (pmps_pkg::func_t'(s_user))
			pmps_pkg::FUNC_CMD: begin
				if (in_angle[17])
					v_d = '0;
				else if (in_angle[16:0] > 17'(pmps_pkg::ANGLE_FULL))
					v_d = 16'(pmps_pkg::ANGLE_FULL);
				else
					v_d = in_angle[15:0];
			end
			pmps_pkg::FUNC_ACCEL: begin
				if (acc_sum[16])
					v_d = '0;
				else if (acc_sum[15:0] > 16'(pmps_pkg::UNIT_FULL))
					v_d = 16'(pmps_pkg::UNIT_FULL);
				else
					v_d = acc_sum[15:0];
			end
			pmps_pkg::FUNC_JOY: begin
				if (in_joy[16])
					v_d = '0;
				else if (in_joy[15:0] > 16'(pmps_pkg::UNIT_FULL))
					v_d = 16'(pmps_pkg::UNIT_FULL);
				else
					v_d = in_joy[15:0];
			end
			default: v_d = '0;
		endcase
	end

	// angle path divides by 46080 = 1024 * 45, unit path by 32768
	always_comb begin
		if (func_s2 == pmps_pkg::FUNC_CMD)
			p_d = PW'(XW'(y_s2[YW-1:10]) * PW'(pmps_pkg::RECIP_45));
		else
			p_d = PW'(y_s2[YW-1:15]) << pmps_pkg::RECIP_SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= pmps_pkg::func_t'(s_user);
			mode_s1 <= pmps_pkg::mode_t'(in_mode);
			prio_s1 <= s_data[27:20];
			jv_s1   <= s_data[61];
			v_s1    <= v_d;

			func_s2 <= func_s1;
			mode_s2 <= mode_s1;
			prio_s2 <= prio_s1;
			jv_s2   <= jv_s1;
			y_s2    <= YW'(v_s1) * YW'(FULL_SCALE_STEPS);

			func_s3 <= func_s2;
			mode_s3 <= mode_s2;
			prio_s3 <= prio_s2;
			jv_s3   <= jv_s2;
			p_s3    <= p_d;
		end
	end

	assign push             = valid_s3 && !q_full;
	assign push_item.func   = func_s3;
	assign push_item.mode   = mode_s3;
	assign push_item.prio   = prio_s3;
	assign push_item.jvalid = jv_s3;
	assign push_item.tgt    = pmps_pkg::TGT_W'(p_s3 >> pmps_pkg::RECIP_SH);

endmodule

[hdl/pmps_queue.sv]
// Short FIFO of classified words between the front and back parts.
// Uses pmps_pkg for the entry type and depth.
module pmps_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pmps_pkg::q_item_t    push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output pmps_pkg::q_item_t    head
);

	pmps_pkg::q_item_t              mem_q [pmps_pkg::QDEPTH];
	logic [pmps_pkg::QPTR_W-1:0]    wr_q, rd_q;
	logic [pmps_pkg::QCNT_W-1:0]    cnt_q;

	assign full  = cnt_q == pmps_pkg::QCNT_W'(pmps_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/pmps_back.sv]
// Back part: mode arbitration, latest targets, the step position, servo angle
// tracking and the output register. Uses pmps_pkg.
module pmps_back #(
	parameter int FULL_SCALE_STEPS = pmps_pkg::FULL_SCALE_STEPS_DEF,
	parameter int SERVO_EVERY      = pmps_pkg::SERVO_EVERY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  pmps_pkg::q_item_t    head,
	output logic                 pop,
	output logic                 m_valid,
	input  logic                 m_ready,
	output logic [31:0]          m_data
);

	localparam int PSW = $clog2(FULL_SCALE_STEPS + 1);
	localparam int RW  = $clog2(FULL_SCALE_STEPS);
	localparam int SW  = (SERVO_EVERY > 1) ? $clog2(SERVO_EVERY) : 1;
	localparam int DQ  = pmps_pkg::ANGLE_FULL / FULL_SCALE_STEPS;
	localparam int DR  = pmps_pkg::ANGLE_FULL % FULL_SCALE_STEPS;

	pmps_pkg::mode_t  mode_q;
	logic [7:0]       prio_q;
	logic             lock_q;
	logic [PSW-1:0]   rem_tgt_q, acc_tgt_q, joy_tgt_q;
	logic             joy_seen_q;
	logic [PSW-1:0]   pos_q;
	logic [SW-1:0]    phase_q;
	logic [15:0]      ang_q;
	logic [RW-1:0]    frac_q;

	logic             tick;
	logic [PSW-1:0]   tgt;
	logic             move, up;
	logic [PSW-1:0]   pos_d;
	logic [SW-1:0]    phase_d;
	logic [15:0]      ang_d;
	logic [RW-1:0]    frac_d;
	logic [RW:0]      frac_up, frac_dn;
	logic             upd;

	assign tick = head.func == pmps_pkg::FUNC_TICK;
	assign pop  = !empty && (!tick || !m_valid || m_ready);

	always_comb begin
		if (lock_q)
			tgt = rem_tgt_q;
		else if (mode_q == pmps_pkg::MODE_JOY)
			tgt = joy_seen_q ? joy_tgt_q : '0;
		else if (mode_q == pmps_pkg::MODE_ACCEL)
			tgt = acc_tgt_q;
		else
			tgt = '0;
	end

	assign move = tgt != pos_q;
	assign up   = tgt > pos_q;

	// pos * 46080 = ang * FULL + frac, kept up to date one step at a time
	assign frac_up = {1'b0, frac_q} + (RW + 1)'(DR);
	assign frac_dn = {1'b0, frac_q} + (RW + 1)'(FULL_SCALE_STEPS - DR);

	always_comb begin
		pos_d   = pos_q;
		phase_d = phase_q;
		ang_d   = ang_q;
		frac_d  = frac_q;
		if (move && up) begin
			pos_d   = pos_q + 1'b1;
			phase_d = (phase_q == SW'(SERVO_EVERY - 1)) ? '0 : phase_q + 1'b1;
			if (frac_up >= (RW + 1)'(FULL_SCALE_STEPS)) begin
				frac_d = RW'(frac_up - (RW + 1)'(FULL_SCALE_STEPS));
				ang_d  = ang_q + 16'(DQ + 1);
			end else begin
				frac_d = RW'(frac_up);
				ang_d  = ang_q + 16'(DQ);
			end
		end else if (move) begin
			pos_d   = pos_q - 1'b1;
			phase_d = (phase_q == '0) ? SW'(SERVO_EVERY - 1) : phase_q - 1'b1;
			if (frac_q < RW'(DR)) begin
				frac_d = RW'(frac_dn);
				ang_d  = ang_q - 16'(DQ + 1);
			end else begin
				frac_d = RW'(frac_q - RW'(DR));
				ang_d  = ang_q - 16'(DQ);
			end
		end
	end

	assign upd = move && (phase_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= pmps_pkg::MODE_NONE;
			prio_q     <= '0;
			lock_q     <= 1'b0;
			rem_tgt_q  <= '0;
			acc_tgt_q  <= '0;
			joy_tgt_q  <= '0;
			joy_seen_q <= 1'b0;
			pos_q      <= '0;
			phase_q    <= '0;
			ang_q      <= '0;
			frac_q     <= '0;
			m_valid    <= 1'b0;
		end else begin
			if (pop && tick)
				m_valid <= 1'b1;
			else if (m_ready)
				m_valid <= 1'b0;
			if (pop) begin
				case (head.func)
					pmps_pkg::FUNC_CMD: begin
						if (head.prio >= prio_q) begin
							mode_q    <= head.mode;
							rem_tgt_q <= PSW'(head.tgt);
							if (head.mode == pmps_pkg::MODE_REMOTE) begin
								prio_q <= head.prio;
								lock_q <= 1'b1;
							end else begin
								prio_q <= '0;
								lock_q <= 1'b0;
							end
						end
					end
					pmps_pkg::FUNC_ACCEL: acc_tgt_q <= PSW'(head.tgt);
					pmps_pkg::FUNC_JOY: begin
						joy_seen_q <= head.jvalid;
						if (head.jvalid)
							joy_tgt_q <= PSW'(head.tgt);
					end
					pmps_pkg::FUNC_TICK: begin
						pos_q   <= pos_d;
						phase_q <= phase_d;
						ang_q   <= ang_d;
						frac_q  <= frac_d;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tick)
			m_data <= {1'b0, 12'(pos_d), (upd ? ang_d : 16'd0), upd, up && move, move};
	end

endmodule
